[rtl/core/bdg_pkg.sv]
// shared types, constants and register map of the button debounce and gesture detector
`default_nettype none
package bdg_pkg;

    // configuration register width and counter width default
    localparam int CFG_WIDTH           = 16;
    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam int APB_DATA_WIDTH      = 32;
    localparam int APB_ADDR_WIDTH      = 4;

    // reset values of the configuration registers
    localparam logic [CFG_WIDTH-1:0] RST_DEBOUNCE_TICKS      = 16'd50;
    localparam logic [CFG_WIDTH-1:0] RST_SHORT_MAX_TICKS     = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] RST_LONG_PRESS_TICKS    = 16'd5000;
    localparam logic [CFG_WIDTH-1:0] RST_DOUBLE_WINDOW_TICKS = 16'd500;

    // register index, word address bits of paddr
    typedef enum logic [1:0] {
        REG_DEBOUNCE      = 2'd0,
        REG_SHORT_MAX     = 2'd1,
        REG_LONG_PRESS    = 2'd2,
        REG_DOUBLE_WINDOW = 2'd3
    } t_reg_idx;

    // event codes on the result channel
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_DOUBLE = 2'd1,
        EV_LONG   = 2'd2
    } t_event;

    // configuration bundle from the register block to the core
    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] short_max_ticks;
        logic [CFG_WIDTH-1:0] long_press_ticks;
        logic [CFG_WIDTH-1:0] double_window_ticks;
    } t_cfg;

    // one result item
    typedef struct packed {
        t_event event_res;
        logic   debounced_level;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/bdg_if.sv]
// valid/ready channel interfaces for tick items and result items
`default_nettype none
interface bdg_tick_if;
    logic valid;
    logic ready;
    logic raw_pressed;

    modport source (output valid, output raw_pressed, input ready);
    modport sink   (input valid, input raw_pressed, output ready);
endinterface

interface bdg_res_if;
    logic            valid;
    logic            ready;
    bdg_pkg::t_event event_res;
    logic            debounced_level;

    modport source (output valid, output event_res, output debounced_level, input ready);
    modport sink   (input valid, input event_res, input debounced_level, output ready);
endinterface
`default_nettype wire

[rtl/core/bdg_cfg_regs.sv]
// apb configuration registers of the debounce and gesture detector
`default_nettype none
module bdg_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bdg_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [bdg_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [bdg_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                    pready,
    output bdg_pkg::t_cfg                           o_cfg
);
    import bdg_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= RST_DEBOUNCE_TICKS;
            r_cfg.short_max_ticks     <= RST_SHORT_MAX_TICKS;
            r_cfg.long_press_ticks    <= RST_LONG_PRESS_TICKS;
            r_cfg.double_window_ticks <= RST_DOUBLE_WINDOW_TICKS;
        end else if (wr_en) begin
            unique case (idx)
                REG_DEBOUNCE:      r_cfg.debounce_ticks      <= pwdata[CFG_WIDTH-1:0];
                REG_SHORT_MAX:     r_cfg.short_max_ticks     <= pwdata[CFG_WIDTH-1:0];
                REG_LONG_PRESS:    r_cfg.long_press_ticks    <= pwdata[CFG_WIDTH-1:0];
                REG_DOUBLE_WINDOW: r_cfg.double_window_ticks <= pwdata[CFG_WIDTH-1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (idx)
            REG_DEBOUNCE:      prdata = APB_DATA_WIDTH'(r_cfg.debounce_ticks);
            REG_SHORT_MAX:     prdata = APB_DATA_WIDTH'(r_cfg.short_max_ticks);
            REG_LONG_PRESS:    prdata = APB_DATA_WIDTH'(r_cfg.long_press_ticks);
            REG_DOUBLE_WINDOW: prdata = APB_DATA_WIDTH'(r_cfg.double_window_ticks);
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/bdg_core.sv]
// debounce and gesture state with its single-tick next-state logic
`default_nettype none
module bdg_core #(
    parameter int COUNT_WIDTH = bdg_pkg::DEFAULT_COUNT_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_raw_pressed,
    input  wire bdg_pkg::t_cfg    i_cfg,
    output bdg_pkg::t_result      o_result
);
    import bdg_pkg::*;

    localparam int CmpW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CntMax) ? v : v + 1'b1;
    endfunction

    logic                   r_prev_raw,   n_prev_raw;
    logic [COUNT_WIDTH-1:0] r_quiet,      n_quiet;
    logic                   r_pending,    n_pending;
    logic                   r_stable,     n_stable;
    logic [COUNT_WIDTH-1:0] r_hold,       n_hold;
    logic                   r_long_rep,   n_long_rep;
    logic [COUNT_WIDTH-1:0] r_since,      n_since;
    logic                   r_click_rec,  n_click_rec;
    t_event                 ev;

    // next state for one tick
    always_comb begin
        n_prev_raw  = r_prev_raw;
        n_quiet     = r_quiet;
        n_pending   = r_pending;
        n_stable    = r_stable;
        n_long_rep  = r_long_rep;
        n_click_rec = r_click_rec;
        ev          = EV_NONE;

        // running counters advance first
        n_hold  = r_stable    ? sat_inc(r_hold)  : r_hold;
        n_since = r_click_rec ? sat_inc(r_since) : r_since;

        if (i_raw_pressed != r_prev_raw) begin
            // raw edge restarts the quiet period
            n_prev_raw = i_raw_pressed;
            n_quiet    = '0;
            n_pending  = 1'b1;
        end else if (r_pending) begin
            n_quiet = sat_inc(r_quiet);
            if (CmpW'(n_quiet) >= CmpW'(i_cfg.debounce_ticks)) begin
                n_pending = 1'b0;
                if (i_raw_pressed != r_stable) begin
                    n_stable   = i_raw_pressed;
                    n_long_rep = 1'b0;
                    if (i_raw_pressed) begin
                        n_hold = '0;
                    end else if (n_hold != CntMax &&
                                 CmpW'(n_hold) <= CmpW'(i_cfg.short_max_ticks)) begin
                        // release of a short press is a click
                        if (r_click_rec && n_since != CntMax &&
                            CmpW'(n_since) <= CmpW'(i_cfg.double_window_ticks)) begin
                            n_click_rec = 1'b0;
                            ev          = EV_DOUBLE;
                        end else begin
                            n_click_rec = 1'b1;
                        end
                        n_since = '0;
                    end
                end
            end
        end

        // long press flagged once per press
        if (n_stable && !n_long_rep &&
            CmpW'(n_hold) >= CmpW'(i_cfg.long_press_ticks)) begin
            n_long_rep = 1'b1;
            ev         = EV_LONG;
        end
    end

    assign o_result.event_res       = ev;
    assign o_result.debounced_level = n_stable;

    // state update on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw  <= 1'b0;
            r_quiet     <= '0;
            r_pending   <= 1'b0;
            r_stable    <= 1'b0;
            r_hold      <= '0;
            r_long_rep  <= 1'b0;
            r_since     <= '0;
            r_click_rec <= 1'b0;
        end else if (i_accept) begin
            r_prev_raw  <= n_prev_raw;
            r_quiet     <= n_quiet;
            r_pending   <= n_pending;
            r_stable    <= n_stable;
            r_hold      <= n_hold;
            r_long_rep  <= n_long_rep;
            r_since     <= n_since;
            r_click_rec <= n_click_rec;
        end
    end

endmodule
`default_nettype wire

[rtl/core/bdg_out_skid.sv]
// result register with a skid stage that takes one more input while output stalls
`default_nettype none
module bdg_out_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire bdg_pkg::t_result i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output bdg_pkg::t_result      o_data
);
    import bdg_pkg::*;

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    in_xfer;
    logic    out_free;

    assign o_ready  = !r_skid_vld;
    assign in_xfer  = i_valid && !r_skid_vld;
    assign out_free = !r_out_vld || i_ready;
    assign o_valid  = r_out_vld;
    assign o_data   = r_out;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld  <= r_skid_vld || in_xfer;
            r_skid_vld <= 1'b0;
        end else if (in_xfer) begin
            r_skid_vld <= 1'b1;
        end
    end

    // payload, skid entry drains first
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : i_data;
        end else if (in_xfer) begin
            r_skid <= i_data;
        end
    end

endmodule
`default_nettype wire

[rtl/core/button_debounce_gesture_detector.sv]
// top level of the button debounce and gesture detector
//
//  channel   dir  handshake      payload
//  i_tick    in   valid/ready    raw_pressed
//  o_res     out  valid/ready    event_res, debounced_level
//  apb       in   psel/penable   four 16-bit registers at byte 0x0, 0x4, 0x8, 0xc
//
// one tick per cycle while input ready is high; its result is registered in the result register
// the state update is one pass of counter increments and compares
// synchronous active-low reset restores register defaults and clears the core state and valid flags
// a stalled result parks in a skid stage; input ready drops only when both are full
`default_nettype none
module button_debounce_gesture_detector #(
    parameter int COUNT_WIDTH = bdg_pkg::DEFAULT_COUNT_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    bdg_tick_if.sink                                i_tick,
    bdg_res_if.source                               o_res,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bdg_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [bdg_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [bdg_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                    pready
);
    import bdg_pkg::*;

    t_cfg    cfg;
    t_result step_res;
    t_result out_res;
    logic    tick_ready;
    logic    tick_xfer;

    assign i_tick.ready = tick_ready;
    assign tick_xfer    = i_tick.valid && tick_ready;

    // configuration registers
    bdg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // debounce and gesture state
    bdg_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (tick_xfer),
        .i_raw_pressed (i_tick.raw_pressed),
        .i_cfg         (cfg),
        .o_result      (step_res)
    );

    // result register and skid stage
    bdg_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_tick.valid),
        .o_ready (tick_ready),
        .i_data  (step_res),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (out_res)
    );

    assign o_res.event_res       = out_res.event_res;
    assign o_res.debounced_level = out_res.debounced_level;

endmodule
`default_nettype wire

[dv/tb_button_debounce_gesture_detector.sv]
// testbench of the button debounce and gesture detector: directed table, random gestures, checks
`timescale 1ns / 1ps
module tb_button_debounce_gesture_detector;
    import bdg_pkg::*;

    localparam int          CLK_PERIOD    = 4;
    localparam int          CW            = DEFAULT_COUNT_WIDTH;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          STALL_CYCLES  = 80;
    localparam int unsigned SECTION_TICKS = 400;
    localparam int unsigned CHUNK_TICKS   = 100;
    localparam logic [CW-1:0] CNT_SAT     = '1;
    localparam t_result     NO_RESULT     = '{EV_NONE, 1'b0};

    // debounce and gesture state of the predictor
    typedef struct packed {
        logic          prev_raw;
        logic [CW-1:0] quiet;
        logic          pending;
        logic          level;
        logic [CW-1:0] hold;
        logic          long_done;
        logic [CW-1:0] gap;
        logic          clicked;
    } t_button;

    // one row of the directed script
    typedef enum logic {ROW_WRITE, ROW_TICKS} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_reg_idx    idx;
        logic [15:0] value;
        logic        raw;
        logic [19:0] reps;
        logic        fixed_want;
        t_event      want_ev;
        logic        want_lvl;
    } t_script_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    bdg_tick_if tick_ch ();
    bdg_res_if  res_ch ();

    t_button     button_state;
    t_cfg        gesture_cfg;
    t_result     tick_outcomes[$];
    int unsigned ticks_sent;
    int unsigned mismatches;
    int unsigned send_gap_pct;
    int unsigned recv_gap_pct;
    logic        stall_req;
    int unsigned stall_left;

    // directed script: reset state, zero debounce and zero long press, clicks and
    // double press, bounce, release against long press, extreme register values
    t_script_row button_script [0:26] = '{
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd4,     1'b1, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b1, 20'd10,    1'b1, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd60,    1'b1, EV_NONE, 1'b0},
        '{ROW_WRITE, REG_DEBOUNCE,      16'd0,     1'b0, 20'd0,     1'b0, EV_NONE, 1'b0},
        '{ROW_WRITE, REG_LONG_PRESS,    16'd0,     1'b0, 20'd0,     1'b0, EV_NONE, 1'b0},
        '{ROW_WRITE, REG_SHORT_MAX,     16'd4,     1'b0, 20'd0,     1'b0, EV_NONE, 1'b0},
        '{ROW_WRITE, REG_DOUBLE_WINDOW, 16'd10,    1'b0, 20'd0,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b1, 20'd3,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd3,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b1, 20'd2,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd3,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b1, 20'd1,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd1,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b1, 20'd1,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd1,     1'b0, EV_NONE, 1'b0},
        '{ROW_WRITE, REG_LONG_PRESS,    16'd3,     1'b0, 20'd0,     1'b0, EV_NONE, 1'b0},
        '{ROW_WRITE, REG_DEBOUNCE,      16'd1,     1'b0, 20'd0,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b1, 20'd3,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd2,     1'b0, EV_NONE, 1'b0},
        '{ROW_WRITE, REG_SHORT_MAX,     16'd65535, 1'b0, 20'd0,     1'b0, EV_NONE, 1'b0},
        '{ROW_WRITE, REG_LONG_PRESS,    16'd65535, 1'b0, 20'd0,     1'b0, EV_NONE, 1'b0},
        '{ROW_WRITE, REG_DOUBLE_WINDOW, 16'd65534, 1'b0, 20'd0,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd20,    1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b1, 20'd20,    1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd3,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b1, 20'd3,     1'b0, EV_NONE, 1'b0},
        '{ROW_TICKS, REG_DEBOUNCE,      16'd0,     1'b0, 20'd3,     1'b0, EV_NONE, 1'b0}
    };

    button_debounce_gesture_detector u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // saturating counter step
    function automatic logic [CW-1:0] sat_up(input logic [CW-1:0] v);
        return (v == CNT_SAT) ? v : v + 1'b1;
    endfunction

    // one tick of the debounce and gesture logic: counters, edge or sample, long press
    function automatic t_result advance_button(input logic raw);
        t_result r;
        r.event_res = EV_NONE;
        if (button_state.level) button_state.hold = sat_up(button_state.hold);
        if (button_state.clicked) button_state.gap = sat_up(button_state.gap);

        if (raw != button_state.prev_raw) begin
            button_state.prev_raw = raw;
            button_state.quiet    = '0;
            button_state.pending  = 1'b1;
        end else if (button_state.pending) begin
            button_state.quiet = sat_up(button_state.quiet);
            if (button_state.quiet >= gesture_cfg.debounce_ticks) begin
                button_state.pending = 1'b0;
                if (raw != button_state.level) begin
                    button_state.level     = raw;
                    button_state.long_done = 1'b0;
                    if (raw) begin
                        button_state.hold = '0;
                    end else if (button_state.hold != CNT_SAT &&
                                 button_state.hold <= gesture_cfg.short_max_ticks) begin
                        // a click: pairs with a recorded one inside the window
                        if (button_state.clicked && button_state.gap != CNT_SAT &&
                            button_state.gap <= gesture_cfg.double_window_ticks) begin
                            button_state.clicked = 1'b0;
                            r.event_res          = EV_DOUBLE;
                        end else begin
                            button_state.clicked = 1'b1;
                        end
                        button_state.gap = '0;
                    end
                end
            end
        end

        // long press, skipped on the tick of a release
        if (button_state.level && !button_state.long_done &&
            button_state.hold >= gesture_cfg.long_press_ticks) begin
            button_state.long_done = 1'b1;
            r.event_res            = EV_LONG;
        end
        r.debounced_level = button_state.level;
        return r;
    endfunction

    // random register value: mostly small so gestures complete, sometimes extremes
    function automatic logic [15:0] pick_count(input int unsigned lo, input int unsigned hi,
                                               input int unsigned small_hi);
        case ($urandom_range(0, 9))
            0: return 16'(lo);
            1: return 16'(hi);
            2: return 16'($urandom_range(hi, lo));
            default: return 16'($urandom_range(small_hi, lo));
        endcase
    endfunction

    // offer one tick until the transfer, then record its predicted outcome
    task automatic send_tick(input logic raw, input logic fixed_want, input t_result want);
        t_result got;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.raw_pressed <= raw;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        got = advance_button(raw);
        tick_outcomes.push_back(fixed_want ? want : got);
        ticks_sent++;
    endtask

    task automatic press_tick(input logic raw);
        send_tick(raw, 1'b0, NO_RESULT);
    endtask

    // stop offering ticks and wait for every outstanding result
    task automatic settle_results();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tick_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, then read back the value just written
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_WIDTH - 16){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_DEBOUNCE:      gesture_cfg.debounce_ticks      = value;
            REG_SHORT_MAX:     gesture_cfg.short_max_ticks     = value;
            REG_LONG_PRESS:    gesture_cfg.long_press_ticks    = value;
            REG_DOUBLE_WINDOW: gesture_cfg.double_window_ticks = value;
            default: ;
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(APB_DATA_WIDTH - 16){1'b0}}, value}) begin
            $error("%s readback: expected %h, got %h", idx.name(), value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // one press with optional contact bounce, then a release gap, or a burst of noise ticks
    task automatic play_gesture();
        int unsigned kind;
        int unsigned span;
        int unsigned press_len;
        int unsigned gap_len;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // noise: isolated random ticks
            repeat ($urandom_range(1, 6)) press_tick($urandom_range(0, 1));
        end else begin
            if (kind < 6) begin
                span = gesture_cfg.short_max_ticks + gesture_cfg.debounce_ticks + 3;
                if (span > 60) span = 60;
            end else begin
                span = gesture_cfg.long_press_ticks + gesture_cfg.debounce_ticks + 4;
                if (span > 120) span = 120;
            end
            press_len = $urandom_range(span, 1);
            span = gesture_cfg.double_window_ticks + gesture_cfg.debounce_ticks + 6;
            if (span > 80) span = 80;
            gap_len = $urandom_range(span, 1);
            repeat ($urandom_range(0, 2)) begin
                press_tick(1'b1);
                press_tick(1'b0);
            end
            repeat (press_len) press_tick(1'b1);
            repeat ($urandom_range(0, 2)) begin
                press_tick(1'b0);
                press_tick(1'b1);
            end
            repeat (gap_len) press_tick(1'b0);
        end
    endtask

    // random gestures in chunks, each chunk under a fresh register setting
    task automatic random_section(input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned start;
        int unsigned chunk_end;
        int unsigned chunk_no;
        t_cfg        next_cfg;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        start        = ticks_sent;
        chunk_no     = 0;
        while (ticks_sent - start < SECTION_TICKS) begin
            settle_results();
            if (chunk_no == 1) begin
                next_cfg = '{16'd1, 16'd0, 16'd1, 16'd0};
            end else if (chunk_no == 3) begin
                next_cfg = '{16'd65535, 16'd65535, 16'd65535, 16'd65534};
            end else begin
                next_cfg.debounce_ticks      = pick_count(1, 65535, 4);
                next_cfg.short_max_ticks     = pick_count(0, 65535, 12);
                next_cfg.long_press_ticks    = pick_count(1, 65535, 40);
                next_cfg.double_window_ticks = pick_count(0, 65534, 30);
            end
            write_reg(REG_DEBOUNCE, next_cfg.debounce_ticks);
            write_reg(REG_SHORT_MAX, next_cfg.short_max_ticks);
            write_reg(REG_LONG_PRESS, next_cfg.long_press_ticks);
            write_reg(REG_DOUBLE_WINDOW, next_cfg.double_window_ticks);
            // long result stall while ticks keep coming, once per section
            if (chunk_no == 0) stall_req = 1'b1;
            chunk_end = ticks_sent + CHUNK_TICKS;
            while (ticks_sent < chunk_end) play_gesture();
            chunk_no++;
        end
    endtask

    // result side ready, with random gaps and requested long stalls
    initial begin : res_sink
        res_ch.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_left = STALL_CYCLES;
                stall_req  = 1'b0;
            end
            if (stall_left != 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    // compare each result transfer with the oldest predicted outcome
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (tick_outcomes.size() == 0) begin
                $error("result with no tick outstanding: event_res %0d debounced_level %0b",
                       res_ch.event_res, res_ch.debounced_level);
                mismatches++;
            end else begin
                want = tick_outcomes.pop_front();
                if (res_ch.event_res !== want.event_res) begin
                    $error("event_res: expected %0d, got %0d", want.event_res, res_ch.event_res);
                    mismatches++;
                end
                if (res_ch.debounced_level !== want.debounced_level) begin
                    $error("debounced_level: expected %0b, got %0b",
                           want.debounced_level, res_ch.debounced_level);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        #10_000_000;
        $display("[button_debounce_gesture_detector] ERROR");
        $finish;
    end

    // reset, directed script, three random sections, final verdict
    initial begin : stimulus
        t_result want;
        i_rst_n             <= 1'b0;
        tick_ch.valid       <= 1'b0;
        tick_ch.raw_pressed <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        stall_req    = 1'b0;
        ticks_sent   = 0;
        mismatches   = 0;
        send_gap_pct = 33;
        recv_gap_pct = 54;
        button_state = '0;
        gesture_cfg  = '{RST_DEBOUNCE_TICKS, RST_SHORT_MAX_TICKS,
                         RST_LONG_PRESS_TICKS, RST_DOUBLE_WINDOW_TICKS};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (button_script[r]) begin
            if (button_script[r].kind == ROW_WRITE) begin
                settle_results();
                write_reg(button_script[r].idx, button_script[r].value);
            end else begin
                want.event_res       = button_script[r].want_ev;
                want.debounced_level = button_script[r].want_lvl;
                repeat (button_script[r].reps)
                    send_tick(button_script[r].raw, button_script[r].fixed_want, want);
            end
        end

        random_section(33, 54);
        random_section(54, 33);
        random_section(0, 0);

        settle_results();
        if (mismatches == 0) begin
            $display("[button_debounce_gesture_detector] OK");
        end else begin
            $display("[button_debounce_gesture_detector] ERROR");
        end
        $finish;
    end

endmodule
